// File: hdl/quaternion_to_euler_unit_macros.svh
// Assertion macros for the quaternion to Euler angle unit
`ifndef QUATERNION_TO_EULER_UNIT_MACROS_SVH
`define QUATERNION_TO_EULER_UNIT_MACROS_SVH
// Assert that a property holds on every clock edge outside reset
`define Q2E_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// Assert that a property holds on every clock edge, reset included
`define Q2E_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) else $error("assertion failed");
`endif

// File: hdl/q2e_pkg.sv
// Shared types, constants and functions for the quaternion to Euler angle unit
`timescale 1ns / 1ps
package q2e_pkg;
    localparam int PROD_W = 36;
    localparam int ANG_W = 31;
    // Square-root datapath width, wide enough for FRAC_BITS up to 20
    localparam int SQ_W = 42;
    localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 31'sd421657428;
    localparam int OUT_PI = 12868;
    localparam int OUT_HALF_PI = 6434;

    // Arctangent table, Q28 radians
    function automatic logic signed [ANG_W-1:0] atan_entry(input int i);
        logic signed [ANG_W-1:0] r;
        case (i)
            0: r = 31'sd210828714;
            1: r = 31'sd124459457;
            2: r = 31'sd65760959;
            3: r = 31'sd33381290;
            4: r = 31'sd16755422;
            5: r = 31'sd8385879;
            6: r = 31'sd4193963;
            7: r = 31'sd2097109;
            8: r = 31'sd1048571;
            9: r = 31'sd524287;
            10: r = 31'sd262144;
            11: r = 31'sd131072;
            12: r = 31'sd65536;
            13: r = 31'sd32768;
            14: r = 31'sd16384;
            15: r = 31'sd8192;
            16: r = 31'sd4096;
            17: r = 31'sd2048;
            18: r = 31'sd1024;
            19: r = 31'sd512;
            20: r = 31'sd256;
            21: r = 31'sd128;
            22: r = 31'sd64;
            23: r = 31'sd32;
            default: r = '0;
        endcase
        return r;
    endfunction

    // Data handed from one vectoring cell to the next
    typedef struct packed {
        logic                     vld;
        logic signed [PROD_W-1:0] x;
        logic signed [PROD_W-1:0] y;
        logic signed [ANG_W-1:0]  z;
    } t_vec;

    // Data handed from one square-root cell to the next
    typedef struct packed {
        logic                     vld;
        logic [SQ_W-1:0]          rem;
        logic [SQ_W-1:0]          root;
    } t_sqr;
endpackage

// File: hdl/q2e_cordic_cell.sv
// One vectoring CORDIC cell: a fixed micro-rotation and a pipeline register
`timescale 1ns / 1ps
module q2e_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  q2e_pkg::t_vec  i_vec,
    output q2e_pkg::t_vec  o_vec
);
    q2e_pkg::t_vec r_vec;
    q2e_pkg::t_vec n_vec;

    // Rotate toward the x axis; shifts floor toward minus infinity
    always_comb begin
        n_vec = i_vec;
        if (i_vec.y >= 0) begin
            n_vec.x = i_vec.x + (i_vec.y >>> STAGE);
            n_vec.y = i_vec.y - (i_vec.x >>> STAGE);
            n_vec.z = i_vec.z + q2e_pkg::atan_entry(STAGE);
        end else begin
            n_vec.x = i_vec.x - (i_vec.y >>> STAGE);
            n_vec.y = i_vec.y + (i_vec.x >>> STAGE);
            n_vec.z = i_vec.z - q2e_pkg::atan_entry(STAGE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vec.vld <= 1'b0;
        end else if (i_en) begin
            r_vec.vld <= n_vec.vld;
        end
        if (i_en) begin
            r_vec.x <= n_vec.x;
            r_vec.y <= n_vec.y;
            r_vec.z <= n_vec.z;
        end
    end

    assign o_vec = r_vec;
endmodule

// File: hdl/q2e_sqrt_cell.sv
// One restoring square-root cell: settles one root bit per cycle while enabled
`timescale 1ns / 1ps
module q2e_sqrt_cell #(
    parameter int STEP = 0,
    parameter int W = 42
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  q2e_pkg::t_sqr  i_sq,
    output q2e_pkg::t_sqr  o_sq
);
    q2e_pkg::t_sqr r_sq;
    q2e_pkg::t_sqr n_sq;
    logic [W-1:0]  bitv;
    logic [W-1:0]  trial;

    // Classic digit-by-digit root, bit weight 4^STEP
    always_comb begin
        bitv  = W'(1) << (2 * STEP);
        trial = i_sq.root + bitv;
        n_sq  = i_sq;
        if (i_sq.rem >= trial) begin
            n_sq.rem  = i_sq.rem - trial;
            n_sq.root = (i_sq.root >> 1) + bitv;
        end else begin
            n_sq.root = i_sq.root >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq.vld <= 1'b0;
        end else if (i_en) begin
            r_sq.vld <= n_sq.vld;
        end
        if (i_en) begin
            r_sq.rem  <= n_sq.rem;
            r_sq.root <= n_sq.root;
        end
    end

    assign o_sq = r_sq;
endmodule

// File: hdl/quaternion_to_euler_unit.sv
// Top level: quaternion in, roll, pitch and yaw out, fully pipelined
`timescale 1ns / 1ps
// Quaternion to Euler angle unit. One request (w, x, y, z in Q1.14) is taken
// every cycle unless the pipeline holds, and its roll and yaw (Q2.12 radians)
// and pitch (Q1.12 radians) come out in order. The pipeline runs through two
// input stages, the row of square-root cells for the pitch cosine (FRAC_BITS + 1
// cells), a quadrant fold, three parallel rows of CORDIC_STAGES vectoring
// cells and the output register; roll and yaw operands ride a delay line
// alongside the square root. The pipeline holds only while a valid result
// waits under i_stall, and o_stall reports that hold.
module quaternion_to_euler_unit #(
    parameter int CORDIC_STAGES = 16,
    parameter int FRAC_BITS = 14
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_quat_w,
    input  logic signed [15:0] i_quat_x,
    input  logic signed [15:0] i_quat_y,
    input  logic signed [15:0] i_quat_z,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [14:0] o_roll_angle,
    output logic signed [13:0] o_pitch_angle,
    output logic signed [14:0] o_yaw_angle
);
    localparam int PW = q2e_pkg::PROD_W;
    localparam int AW = q2e_pkg::ANG_W;
    localparam int SH = 28 - FRAC_BITS;
    localparam int SW = q2e_pkg::SQ_W;
    localparam int NSQ = FRAC_BITS + 1;
    localparam int SFW = FRAC_BITS + 2;
    localparam logic signed [PW-1:0] ONE = PW'(64'sd1 << 28);

    logic en;
    assign en = !(o_valid && i_stall);
    assign o_stall = !en;

    // Stage 1: products, each 16 x 16 into 32 bits
    logic signed [31:0] p_wx, p_yz, p_xx, p_yy, p_wy, p_zx, p_wz, p_xy, p_zz;
    assign p_wx = i_quat_w * i_quat_x;
    assign p_yz = i_quat_y * i_quat_z;
    assign p_xx = i_quat_x * i_quat_x;
    assign p_yy = i_quat_y * i_quat_y;
    assign p_wy = i_quat_w * i_quat_y;
    assign p_zx = i_quat_z * i_quat_x;
    assign p_wz = i_quat_w * i_quat_z;
    assign p_xy = i_quat_x * i_quat_y;
    assign p_zz = i_quat_z * i_quat_z;

    logic r_v1;
    logic signed [PW-1:0] r_sr, r_cr, r_s, r_sy, r_cy;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
        end
        if (en) begin
            r_sr <= 2 * (PW'(p_wx) + PW'(p_yz));
            r_cr <= ONE - 2 * (PW'(p_xx) + PW'(p_yy));
            r_s  <= 2 * (PW'(p_wy) - PW'(p_zx));
            r_sy <= 2 * (PW'(p_wz) + PW'(p_xy));
            r_cy <= ONE - 2 * (PW'(p_yy) + PW'(p_zz));
        end
    end

    // Stage 2: reduce, pitch square and range flags
    logic r_v2, r_phi, r_plo;
    logic signed [PW-1:0] r_rsr, r_rcr, r_rsf, r_rsy, r_rcy;
    logic signed [PW-1:0] n_sf;
    logic signed [SFW-1:0] n_sf_n;
    logic signed [2*SFW-1:0] n_sq2;
    logic [SW-1:0] r_sq_rem;
    // Only an in-range sine reaches the square, so it fits FRAC_BITS + 2 bits
    assign n_sf = r_s >>> SH;
    assign n_sf_n = SFW'(n_sf);
    assign n_sq2 = n_sf_n * n_sf_n;
    q2e_pkg::t_sqr sq_in;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v2 <= r_v1;
        end
        if (en) begin
            r_rsr <= r_sr >>> SH;
            r_rcr <= r_cr >>> SH;
            r_rsy <= r_sy >>> SH;
            r_rcy <= r_cy >>> SH;
            r_rsf <= n_sf;
            r_phi <= r_s >= ONE;
            r_plo <= r_s <= -ONE;
            r_sq_rem <= (r_s >= ONE || r_s <= -ONE) ? '0
                : SW'((64'sd1 <<< (2 * FRAC_BITS)) - 64'(n_sq2));
        end
    end
    assign sq_in = '{vld: r_v2, rem: r_sq_rem, root: '0};

    // Square-root row
    q2e_pkg::t_sqr sq [NSQ+1];
    assign sq[0] = sq_in;
    for (genvar g = 0; g < NSQ; g++) begin : g_sqrt
        q2e_sqrt_cell #(.STEP(NSQ - 1 - g), .W(SW)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_sq(sq[g]), .o_sq(sq[g+1])
        );
    end

    // Delay line for the operands that skip the square root
    logic signed [PW-1:0] r_d_sr [NSQ], r_d_cr [NSQ], r_d_sy [NSQ], r_d_cy [NSQ];
    logic signed [PW-1:0] r_d_sf [NSQ];
    logic r_d_hi [NSQ], r_d_lo [NSQ];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_sr[0] <= r_rsr; r_d_cr[0] <= r_rcr;
            r_d_sy[0] <= r_rsy; r_d_cy[0] <= r_rcy;
            r_d_sf[0] <= r_rsf; r_d_hi[0] <= r_phi; r_d_lo[0] <= r_plo;
            for (int k = 1; k < NSQ; k++) begin
                r_d_sr[k] <= r_d_sr[k-1]; r_d_cr[k] <= r_d_cr[k-1];
                r_d_sy[k] <= r_d_sy[k-1]; r_d_cy[k] <= r_d_cy[k-1];
                r_d_sf[k] <= r_d_sf[k-1]; r_d_hi[k] <= r_d_hi[k-1];
                r_d_lo[k] <= r_d_lo[k-1];
            end
        end
    end

    // Quadrant fold before the CORDIC rows
    function automatic q2e_pkg::t_vec fold(input logic v, input logic signed [PW-1:0] y,
                                           input logic signed [PW-1:0] x);
        q2e_pkg::t_vec r;
        r.vld = v;
        r.x = x;
        r.y = y;
        r.z = '0;
        if (x < 0) begin
            if (y >= 0) begin
                r.x = y; r.y = -x; r.z = q2e_pkg::ANG_HALF_PI;
            end else begin
                r.x = -y; r.y = x; r.z = -q2e_pkg::ANG_HALF_PI;
            end
        end
        return r;
    endfunction

    q2e_pkg::t_vec r_f_roll, r_f_pit, r_f_yaw;
    q2e_pkg::t_vec n_f_roll, n_f_pit, n_f_yaw;
    logic r_zr, r_zp, r_zy;
    logic r_phi2 [CORDIC_STAGES+1], r_plo2 [CORDIC_STAGES+1];
    logic r_zr2 [CORDIC_STAGES], r_zp2 [CORDIC_STAGES], r_zy2 [CORDIC_STAGES];
    logic signed [PW-1:0] n_c;
    assign n_c = PW'(sq[NSQ].root);
    assign n_f_roll = fold(sq[NSQ].vld, r_d_sr[NSQ-1], r_d_cr[NSQ-1]);
    assign n_f_yaw  = fold(sq[NSQ].vld, r_d_sy[NSQ-1], r_d_cy[NSQ-1]);
    assign n_f_pit  = fold(sq[NSQ].vld, r_d_sf[NSQ-1], n_c);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_roll.vld <= 1'b0;
            r_f_pit.vld  <= 1'b0;
            r_f_yaw.vld  <= 1'b0;
        end else if (en) begin
            r_f_roll.vld <= n_f_roll.vld;
            r_f_pit.vld  <= n_f_pit.vld;
            r_f_yaw.vld  <= n_f_yaw.vld;
        end
        if (en) begin
            {r_f_roll.x, r_f_roll.y, r_f_roll.z} <= {n_f_roll.x, n_f_roll.y, n_f_roll.z};
            {r_f_yaw.x, r_f_yaw.y, r_f_yaw.z} <= {n_f_yaw.x, n_f_yaw.y, n_f_yaw.z};
            {r_f_pit.x, r_f_pit.y, r_f_pit.z} <= {n_f_pit.x, n_f_pit.y, n_f_pit.z};
            r_zr <= r_d_sr[NSQ-1] == 0 && r_d_cr[NSQ-1] == 0;
            r_zy <= r_d_sy[NSQ-1] == 0 && r_d_cy[NSQ-1] == 0;
            r_zp <= r_d_sf[NSQ-1] == 0 && n_c == 0;
            r_phi2[0] <= r_d_hi[NSQ-1];
            r_plo2[0] <= r_d_lo[NSQ-1];
            r_zr2[0] <= r_zr; r_zy2[0] <= r_zy; r_zp2[0] <= r_zp;
            r_phi2[1] <= r_phi2[0]; r_plo2[1] <= r_plo2[0];
            for (int k = 1; k < CORDIC_STAGES; k++) begin
                r_zr2[k] <= r_zr2[k-1]; r_zy2[k] <= r_zy2[k-1]; r_zp2[k] <= r_zp2[k-1];
                r_phi2[k+1] <= r_phi2[k]; r_plo2[k+1] <= r_plo2[k];
            end
        end
    end

    // Three rows of CORDIC cells
    q2e_pkg::t_vec cr_roll [CORDIC_STAGES+1];
    q2e_pkg::t_vec cr_pit  [CORDIC_STAGES+1];
    q2e_pkg::t_vec cr_yaw  [CORDIC_STAGES+1];
    assign cr_roll[0] = r_f_roll;
    assign cr_pit[0]  = r_f_pit;
    assign cr_yaw[0]  = r_f_yaw;
    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
        q2e_cordic_cell #(.STAGE(g)) u_roll (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_vec(cr_roll[g]), .o_vec(cr_roll[g+1])
        );
        q2e_cordic_cell #(.STAGE(g)) u_pit (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_vec(cr_pit[g]), .o_vec(cr_pit[g+1])
        );
        q2e_cordic_cell #(.STAGE(g)) u_yaw (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_vec(cr_yaw[g]), .o_vec(cr_yaw[g+1])
        );
    end

    // Round to Q12 and clamp
    function automatic logic signed [15:0] to_out(input logic signed [AW-1:0] z,
                                                  input logic zero, input int lim);
        logic signed [AW:0] r;
        r = (AW+1)'(z + (AW+1)'(32768)) >>> 16;
        if (zero) r = '0;
        if (r > lim) r = (AW+1)'(lim);
        if (r < -lim) r = -(AW+1)'(lim);
        return 16'(r);
    endfunction

    logic signed [15:0] n_roll, n_pit, n_yaw;
    assign n_roll = to_out(cr_roll[CORDIC_STAGES].z, r_zr2[CORDIC_STAGES-1],
                           q2e_pkg::OUT_PI);
    assign n_yaw = to_out(cr_yaw[CORDIC_STAGES].z, r_zy2[CORDIC_STAGES-1],
                          q2e_pkg::OUT_PI);
    assign n_pit = r_phi2[CORDIC_STAGES] ? 16'(q2e_pkg::OUT_HALF_PI)
                 : r_plo2[CORDIC_STAGES] ? -16'(q2e_pkg::OUT_HALF_PI)
                 : to_out(cr_pit[CORDIC_STAGES].z, r_zp2[CORDIC_STAGES-1],
                          q2e_pkg::OUT_HALF_PI);

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (en) begin
            o_valid <= cr_roll[CORDIC_STAGES].vld;
        end
        if (en) begin
            o_roll_angle  <= 15'(n_roll);
            o_pitch_angle <= 14'(n_pit);
            o_yaw_angle   <= 15'(n_yaw);
        end
    end
endmodule

// File: hdl/q2e_checker.sv
// Port-level checker for the quaternion to Euler angle unit, with its bind
`timescale 1ns / 1ps
`include "quaternion_to_euler_unit_macros.svh"
module q2e_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [14:0] o_roll_angle,
    input logic signed [13:0] o_pitch_angle,
    input logic signed [14:0] o_yaw_angle
);
    `Q2E_ASSERT(a_stall_follows, i_clk, i_rst_n, o_stall == (o_valid && i_stall))
    `Q2E_ASSERT(a_out_hold, i_clk, i_rst_n, (o_valid && i_stall) |=> (o_valid && $stable(o_pitch_angle)))
    `Q2E_ASSERT(a_pitch_range, i_clk, i_rst_n, !o_valid || (o_pitch_angle <= 14'sd6434 && o_pitch_angle >= -14'sd6434))
    `Q2E_ASSERT(a_roll_range, i_clk, i_rst_n, !o_valid || (o_roll_angle <= 15'sd12868 && o_roll_angle >= -15'sd12868))
    `Q2E_ASSERT(a_yaw_range, i_clk, i_rst_n, !o_valid || (o_yaw_angle <= 15'sd12868 && o_yaw_angle >= -15'sd12868))
endmodule

bind quaternion_to_euler_unit q2e_checker u_q2e_checker (.*);
